// File: sv/rhc_pkg.sv
// Package for the RGB to HSV converter: field widths, payload and tag types,
// sector codes and the hue constants. Depends on nothing.
package rhc_pkg;

	localparam int CH_W          = 8;
	localparam int HUE_W         = 15;
	localparam int DIV_STEP_BITS = 4;

	localparam int DEG_PER_SECTOR = 60;
	localparam int OFFSET_GREEN   = 120;
	localparam int OFFSET_BLUE    = 240;
	localparam int FULL_TURN      = 360;
	localparam int SAT_SCALE      = 255;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [CH_W-1:0]  sat;
		logic [CH_W-1:0]  val;
	} hsv_t;

	// side information that rides along with the divider
	typedef struct packed {
		sector_t         sector;
		logic            neg;
		logic            gray;
		logic [CH_W-1:0] val;
	} hsv_tag_t;

endpackage

// File: sv/rhc_stream_if.sv
// Valid/ready stream interface used for the pixel input and output channels.
// Self-contained; the payload type is given per instance.
interface rhc_stream_if #(parameter type data_t = logic);

	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);

endinterface

// File: sv/rhc_div_pipe.sv
// Pipelined restoring divider, several lanes in lockstep, with a tag that
// travels alongside. Uses rhc_pkg for the number of quotient bits per stage.
module rhc_div_pipe
	import rhc_pkg::*;
#(
	parameter int LANES = 2,
	parameter int NUM_W = 21,
	parameter int DEN_W = 9,
	parameter int Q_W   = 12,
	parameter int TAG_W = 12
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [LANES-1:0][NUM_W-1:0] num,
	input  logic [LANES-1:0][DEN_W-1:0] den,
	input  logic [TAG_W-1:0]            in_tag,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [LANES-1:0][Q_W-1:0]   quo,
	output logic [TAG_W-1:0]            out_tag
);

	localparam int NS = (Q_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS;

	logic [NS:0]   vld_s;
	logic [NS+1:0] rdy;

	logic [LANES-1:0][DEN_W-1:0] rem_s [NS+1];
	logic [LANES-1:0][Q_W-1:0]   nlo_s [NS+1];
	logic [LANES-1:0][Q_W-1:0]   quo_s [NS+1];
	logic [LANES-1:0][DEN_W-1:0] den_s [NS+1];
	logic [TAG_W-1:0]            tag_s [NS+1];

	logic [LANES-1:0][DEN_W-1:0] rem_n [1:NS];
	logic [LANES-1:0][Q_W-1:0]   nlo_n [1:NS];
	logic [LANES-1:0][Q_W-1:0]   quo_n [1:NS];

	// a stage may load when it is empty or its word moves on
	always_comb begin
		rdy[NS+1] = out_ready;
		for (int j = NS; j >= 0; j--) begin
			rdy[j] = !vld_s[j] || rdy[j+1];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_s[NS];
	assign quo       = quo_s[NS];
	assign out_tag   = tag_s[NS];

	for (genvar j = 1; j <= NS; j++) begin : g_stage
		for (genvar l = 0; l < LANES; l++) begin : g_lane
			logic [DEN_W-1:0] rem_c;
			logic [Q_W-1:0]   nlo_c;
			logic [Q_W-1:0]   quo_c;

			always_comb begin
				logic [DEN_W:0] trial;
				trial = '0;
				rem_c = rem_s[j-1][l];
				nlo_c = nlo_s[j-1][l];
				quo_c = quo_s[j-1][l];
				for (int s = 0; s < DIV_STEP_BITS; s++) begin
					if ((j - 1) * DIV_STEP_BITS + s < Q_W) begin
						trial = {rem_c, nlo_c[Q_W-1]};
						if (trial >= {1'b0, den_s[j-1][l]}) begin
							rem_c = DEN_W'(trial - {1'b0, den_s[j-1][l]});
							quo_c = {quo_c[Q_W-2:0], 1'b1};
						end else begin
							rem_c = trial[DEN_W-1:0];
							quo_c = {quo_c[Q_W-2:0], 1'b0};
						end
						nlo_c = {nlo_c[Q_W-2:0], 1'b0};
					end
				end
			end

			assign rem_n[j][l] = rem_c;
			assign nlo_n[j][l] = nlo_c;
			assign quo_n[j][l] = quo_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[0]) begin
				vld_s[0] <= in_valid;
			end
			for (int j = 1; j <= NS; j++) begin
				if (rdy[j]) begin
					vld_s[j] <= vld_s[j-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[0] && in_valid) begin
			for (int l = 0; l < LANES; l++) begin
				// upper dividend bits start as the partial remainder
				rem_s[0][l] <= DEN_W'(num[l] >> Q_W);
				nlo_s[0][l] <= num[l][Q_W-1:0];
				quo_s[0][l] <= '0;
			end
			den_s[0] <= den;
			tag_s[0] <= in_tag;
		end
		for (int j = 1; j <= NS; j++) begin
			if (rdy[j] && vld_s[j-1]) begin
				rem_s[j] <= rem_n[j];
				nlo_s[j] <= nlo_n[j];
				quo_s[j] <= quo_n[j];
				den_s[j] <= den_s[j-1];
				tag_s[j] <= tag_s[j-1];
			end
		end
	end

`ifndef SYNTHESIS
	for (genvar j = 0; j <= NS; j++) begin : g_chk
		for (genvar l = 0; l < LANES; l++) begin : g_chk_lane
			a_rem_below_den: assert property (@(posedge clk) disable iff (!arst_n)
				vld_s[j] && den_s[j][l] != '0 |-> rem_s[j][l] < den_s[j][l])
				else $error("partial remainder not below divisor");
		end
		if (j < NS) begin : g_hold
			a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
				vld_s[j] && !rdy[j+1] |=> vld_s[j])
				else $error("stalled divider word dropped");
		end
	end

	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> &vld_s)
		else $error("divider refuses input with a free stage");
`endif

endmodule

// File: sv/rgb_to_hsv_convert_top.sv
// RGB to HSV converter, top level: channel classification, pipelined dividers
// and the hue assembly. Depends on rhc_pkg, rhc_stream_if and rhc_div_pipe.
//
//  channel   dir  payload             meaning
//  pix_in    in   red, green, blue    one RGB pixel word
//  pix_out   out  hue, sat, val       one HSV pixel word
//
// One pixel word is accepted per cycle while pix_out does not stall; a pixel
// passes the front stage register, the divider stages, which resolve four of
// the Q = max(HUE_FRACTION_BITS + 6, 8) quotient bits each, and the output register.
// arst_n clears only the valid bits; payload registers are not reset.
// Each stage loads whenever it is empty or its word moves on, so bubbles close
// up behind a stalled output and pix_in stays ready until every stage is full.
module rgb_to_hsv_convert_top
	import rhc_pkg::*;
#(
	parameter int HUE_FRACTION_BITS = 6
) (
	input  logic         clk,
	input  logic         arst_n,
	rhc_stream_if.sink   pix_in,
	rhc_stream_if.source pix_out
);

	localparam int UNITS     = 1 << HUE_FRACTION_BITS;
	localparam int HUE_NUM_W = HUE_FRACTION_BITS + 15;
	localparam int SAT_NUM_W = 17;
	localparam int NUM_W     = (HUE_NUM_W > SAT_NUM_W) ? HUE_NUM_W : SAT_NUM_W;
	localparam int Q_W       = (HUE_FRACTION_BITS + 6 > CH_W) ? HUE_FRACTION_BITS + 6 : CH_W;
	localparam int DEN_W     = CH_W + 1;
	localparam int H_W       = (HUE_FRACTION_BITS + 11 > HUE_W + 1) ?
		HUE_FRACTION_BITS + 11 : HUE_W + 1;
	localparam int TAG_W     = $bits(hsv_tag_t);
	localparam int LANE_HUE  = 0;
	localparam int LANE_SAT  = 1;
	localparam int LANES     = 2;

	// front stage: max, min, sector and the signed difference
	logic [CH_W-1:0] hi_c, lo_c, minu_c, subt_c;
	sector_t         sector_c;

	logic            v_s1;
	logic            rdy_s1;
	logic [CH_W-1:0] hi_s1, delta_s1, mag_s1;
	logic            neg_s1;
	sector_t         sector_s1;

	logic                        div_in_ready;
	logic [LANES-1:0][NUM_W-1:0] div_num;
	logic [LANES-1:0][DEN_W-1:0] div_den;
	hsv_tag_t                    tag_in;

	logic                      div_out_valid;
	logic                      div_out_ready;
	logic [LANES-1:0][Q_W-1:0] div_quo;
	logic [TAG_W-1:0]          div_tag;
	hsv_tag_t                  tag_out;

	logic signed [H_W-1:0] base_c, part_c, hue_c;
	hsv_t                  res_c;

	logic out_vld_q;
	hsv_t out_q;

	always_comb begin
		if (pix_in.data.red >= pix_in.data.green && pix_in.data.red >= pix_in.data.blue) begin
			sector_c = SECT_RED;
		end else if (pix_in.data.green >= pix_in.data.blue) begin
			sector_c = SECT_GREEN;
		end else begin
			sector_c = SECT_BLUE;
		end

		lo_c = pix_in.data.red;
		if (pix_in.data.green < lo_c) lo_c = pix_in.data.green;
		if (pix_in.data.blue < lo_c) lo_c = pix_in.data.blue;

		unique case (sector_c)
			SECT_RED: begin
				hi_c   = pix_in.data.red;
				minu_c = pix_in.data.green;
				subt_c = pix_in.data.blue;
			end
			SECT_GREEN: begin
				hi_c   = pix_in.data.green;
				minu_c = pix_in.data.blue;
				subt_c = pix_in.data.red;
			end
			SECT_BLUE: begin
				hi_c   = pix_in.data.blue;
				minu_c = pix_in.data.red;
				subt_c = pix_in.data.green;
			end
			default: begin
				hi_c   = pix_in.data.red;
				minu_c = pix_in.data.green;
				subt_c = pix_in.data.blue;
			end
		endcase
	end

	assign rdy_s1       = !v_s1 || div_in_ready;
	assign pix_in.ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= pix_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && pix_in.valid) begin
			hi_s1     <= hi_c;
			delta_s1  <= hi_c - lo_c;
			neg_s1    <= minu_c < subt_c;
			mag_s1    <= (minu_c < subt_c) ? subt_c - minu_c : minu_c - subt_c;
			sector_s1 <= sector_c;
		end
	end

	// round-to-nearest quotients: (2*n + d) / (2*d)
	always_comb begin
		div_num[LANE_HUE] = NUM_W'(mag_s1) * NUM_W'(2 * DEG_PER_SECTOR * UNITS)
			+ NUM_W'(delta_s1);
		div_den[LANE_HUE] = {delta_s1, 1'b0};
		div_num[LANE_SAT] = NUM_W'(delta_s1) * NUM_W'(2 * SAT_SCALE) + NUM_W'(hi_s1);
		div_den[LANE_SAT] = {hi_s1, 1'b0};
		tag_in.sector     = sector_s1;
		tag_in.neg        = neg_s1;
		tag_in.gray       = (delta_s1 == '0);
		tag_in.val        = hi_s1;
	end

	rhc_div_pipe #(
		.LANES (LANES),
		.NUM_W (NUM_W),
		.DEN_W (DEN_W),
		.Q_W   (Q_W),
		.TAG_W (TAG_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.in_ready  (div_in_ready),
		.num       (div_num),
		.den       (div_den),
		.in_tag    (TAG_W'(tag_in)),
		.out_valid (div_out_valid),
		.out_ready (div_out_ready),
		.quo       (div_quo),
		.out_tag   (div_tag)
	);

	assign tag_out = hsv_tag_t'(div_tag);

	always_comb begin
		unique case (tag_out.sector)
			SECT_RED:   base_c = '0;
			SECT_GREEN: base_c = H_W'(OFFSET_GREEN * UNITS);
			SECT_BLUE:  base_c = H_W'(OFFSET_BLUE * UNITS);
			default:    base_c = '0;
		endcase
		part_c = H_W'(div_quo[LANE_HUE]);
		hue_c  = tag_out.neg ? base_c - part_c : base_c + part_c;
		// wrap a negative angle into the full turn
		if (hue_c[H_W-1]) begin
			hue_c = hue_c + H_W'(FULL_TURN * UNITS);
		end
		res_c.hue = tag_out.gray ? '0 : hue_c[HUE_W-1:0];
		res_c.sat = tag_out.gray ? '0 : div_quo[LANE_SAT][CH_W-1:0];
		res_c.val = tag_out.val;
	end

	assign div_out_ready = !out_vld_q || pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (div_out_ready) begin
			out_vld_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (div_out_ready && div_out_valid) begin
			out_q <= res_c;
		end
	end

	assign pix_out.valid = out_vld_q;
	assign pix_out.data  = out_q;

`ifndef SYNTHESIS
	a_sat_needs_val: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.data.sat != '0 |-> pix_out.data.val != '0)
		else $error("nonzero saturation on a black pixel");

	a_hue_in_turn: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid |-> (HUE_FRACTION_BITS > 6) ||
		(pix_out.data.hue < HUE_W'(FULL_TURN * UNITS)))
		else $error("hue beyond a full turn");

	a_quo_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_out_valid && !tag_out.gray |->
		div_quo[LANE_SAT] <= Q_W'(SAT_SCALE) &&
		div_quo[LANE_HUE] <= Q_W'(DEG_PER_SECTOR * UNITS))
		else $error("divider quotient out of range");
`endif

endmodule
